// ===== rtl/lldq_pkg.sv =====
// ---------------------------------------------------------------------------
// lldq_pkg
// Types and constants shared by the linked-list deque engine.
// ---------------------------------------------------------------------------
package lldq_pkg;

	localparam int unsigned CAPACITY_DEF   = 32;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	typedef enum logic [3:0] {
		REQ_PUSH_FRONT  = 4'd0,
		REQ_PUSH_BACK   = 4'd1,
		REQ_INS_AFTER   = 4'd2,
		REQ_INS_BEFORE  = 4'd3,
		REQ_PEEK_FRONT  = 4'd4,
		REQ_PEEK_BACK   = 4'd5,
		REQ_POP_FRONT   = 4'd6,
		REQ_POP_BACK    = 4'd7,
		REQ_REMOVE_KEY  = 4'd8,
		REQ_FIND_KEY    = 4'd9
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} resp_code_t;

	typedef struct packed {
		logic [3:0]         req_type;
		logic signed [31:0] key_value;
		logic signed [31:0] new_value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
		logic [5:0]         length;
		logic               is_empty;
	} rsp_t;

endpackage

// ===== rtl/lldq_ram.sv =====
// ---------------------------------------------------------------------------
// lldq_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module lldq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/linked_list_deque_engine_core.sv =====
// ---------------------------------------------------------------------------
// linked_list_deque_engine_core
// Bounded doubly linked list (deque + keyed search) in node RAMs.
// ---------------------------------------------------------------------------
// Steps: peek, empty, full push and unused codes go read, check, respond; pop adds link,
// fix and fix2 before respond; push also allocates before link. Key requests repeat read
// and check per node passed over; on a hit, remove and insert continue as pop and push do.
// Flow: one request in flight; the next is accepted once the engine is back in idle after
// raising the result, while that result may still wait in the output register.
// Reset: list empty, bump and recycle counters zero; node RAMs hold no reset value. Free nodes come from
// a bump allocator plus a recycled-node stack RAM.
module linked_list_deque_engine_core
	import lldq_pkg::*;
#(
	parameter int unsigned CAPACITY   = CAPACITY_DEF,
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_data
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned LW = AW + 1; // link with null bit
	localparam int unsigned NW = DATA_WIDTH + 2 * LW;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_RD    = 8'b0000_0010,
		S_CHK   = 8'b0000_0100,
		S_LINK  = 8'b0000_1000,
		S_FIX   = 8'b0001_0000,
		S_FIX2  = 8'b0010_0000,
		S_RSP   = 8'b0100_0000,
		S_ALLOC = 8'b1000_0000
	} state_t;

	state_t state_q;
	req_t req_q;
	logic [DATA_WIDTH-1:0] key_q, nv_q;
	logic [LW-1:0] front_q, back_q, cur_q, hit_q, newn_q, walk_q;
	logic [CW-1:0] count_q, bump_q, rec_q;
	logic [1:0] st_q;
	logic [DATA_WIDTH-1:0] rd_q;
	logic [CW-1:0] steps_q;
	logic [LW-1:0] fa_q, fb_q; // fix-up link targets
	rsp_t rsp_q;
	logic rsp_v_q;

	// node RAM: {data, prev, next}
	logic nd_we;
	logic [AW-1:0] nd_wa, nd_ra;
	logic [NW-1:0] nd_wd, nd_rd;
	logic [DATA_WIDTH-1:0] rd_data;
	logic [LW-1:0] rd_prev, rd_next;
	// recycled node stack
	logic fs_we;
	logic [AW-1:0] fs_wa, fs_ra;
	logic [AW-1:0] fs_wd, fs_rd;

	lldq_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_node (
		.clk, .we(nd_we), .waddr(nd_wa), .wdata(nd_wd), .raddr(nd_ra), .rdata(nd_rd));
	lldq_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free (
		.clk, .we(fs_we), .waddr(fs_wa), .wdata(fs_wd), .raddr(fs_ra), .rdata(fs_rd));

	assign {rd_data, rd_prev, rd_next} = nd_rd;

	function automatic logic [DATA_WIDTH-1:0] to_data(input logic [31:0] v);
		logic [63:0] x;
		x = {{32{v[31]}}, v};
		return x[DATA_WIDTH-1:0];
	endfunction

	function automatic logic is_null(input logic [LW-1:0] l);
		return l[LW-1:AW] != '0 || l >= LW'(CAPACITY);
	endfunction

	localparam logic [LW-1:0] NULL_L = LW'(CAPACITY);

	// node RAM has one write port, so a link fix rewrites the whole entry
	// read back just before it
	logic full;
	assign full = (bump_q == CW'(CAPACITY)) && (rec_q == '0);

	// a finished result parks in rsp_q; the next request may start meanwhile
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = rsp_v_q;
	assign out_data = rsp_q;

	logic is_ins, is_push, is_search;
	req_type_t rt;
	assign rt = req_type_t'(req_q.req_type);
	assign is_push = (rt == REQ_PUSH_FRONT) || (rt == REQ_PUSH_BACK);
	assign is_ins = (rt == REQ_INS_AFTER) || (rt == REQ_INS_BEFORE);
	assign is_search = is_ins || (rt == REQ_REMOVE_KEY) || (rt == REQ_FIND_KEY);

	always_comb begin
		nd_we = 1'b0;
		nd_wa = '0;
		nd_wd = '0;
		nd_ra = cur_q[AW-1:0];
		fs_we = 1'b0;
		fs_wa = '0;
		fs_wd = '0;
		fs_ra = AW'(rec_q - CW'(1));
		case (state_q)
			S_LINK: begin
				// write the new node on insert
				nd_we = is_push || is_ins;
				nd_wa = newn_q[AW-1:0];
				nd_wd = {nv_q, fa_q, fb_q};
				nd_ra = fa_q[AW-1:0];
			end
			S_FIX: begin
				nd_ra = fb_q[AW-1:0];
				if (!is_null(walk_q)) begin
					// a.next: new node on insert, b on unlink
					nd_we = 1'b1;
					nd_wa = walk_q[AW-1:0];
					nd_wd = {rd_data, rd_prev, (is_push || is_ins) ? newn_q : fb_q};
				end
			end
			S_FIX2: begin
				if (!is_null(cur_q)) begin
					nd_we = 1'b1;
					nd_wa = cur_q[AW-1:0];
					nd_wd = {rd_data, newn_q, rd_next};
				end
				fs_we = !(is_push || is_ins);
				fs_wa = rec_q[AW-1:0];
				fs_wd = hit_q[AW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q   <= '0;
			key_q   <= '0;
			nv_q    <= '0;
			front_q <= NULL_L;
			back_q  <= NULL_L;
			cur_q   <= NULL_L;
			hit_q   <= NULL_L;
			newn_q  <= NULL_L;
			walk_q  <= NULL_L;
			count_q <= '0;
			bump_q  <= '0;
			rec_q   <= '0;
			st_q    <= ST_OK;
			rd_q    <= '0;
			steps_q <= '0;
			fa_q    <= NULL_L;
			fb_q    <= NULL_L;
			rsp_q   <= '0;
			rsp_v_q <= 1'b0;
		end else begin
			if (rsp_v_q && !out_stall) rsp_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						req_q   <= in_data;
						key_q   <= to_data(in_data.key_value);
						nv_q    <= to_data(in_data.new_value);
						st_q    <= ST_OK;
						rd_q    <= '0;
						steps_q <= '0;
						state_q <= S_RD;
						case (req_type_t'(in_data.req_type))
							REQ_PEEK_BACK, REQ_POP_BACK: cur_q <= back_q;
							default: cur_q <= front_q;
						endcase
					end
				end
				S_RD: begin
					// read issued for cur_q (and top of recycled stack)
					state_q <= S_CHK;
				end
				S_CHK: begin
					state_q <= S_RSP;
					case (rt)
						REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
							if (full) st_q <= ST_FULL;
							else begin
								fa_q <= (rt == REQ_PUSH_BACK) ? back_q : NULL_L;
								fb_q <= (rt == REQ_PUSH_BACK) ? NULL_L : front_q;
								state_q <= S_ALLOC;
							end
						end
						REQ_PEEK_FRONT, REQ_PEEK_BACK, REQ_POP_FRONT, REQ_POP_BACK: begin
							if (count_q == '0 || is_null(cur_q)) st_q <= ST_EMPTY;
							else begin
								rd_q <= rd_data;
								if (rt == REQ_POP_FRONT || rt == REQ_POP_BACK) begin
									hit_q <= cur_q;
									fa_q <= rd_prev;
									fb_q <= rd_next;
									state_q <= S_LINK;
								end
							end
						end
						REQ_INS_AFTER, REQ_INS_BEFORE, REQ_REMOVE_KEY, REQ_FIND_KEY: begin
							if (is_null(cur_q) || steps_q == CW'(CAPACITY)) begin
								st_q <= ST_NOTFOUND;
							end else if (rd_data == key_q) begin
								hit_q <= cur_q;
								if (rt == REQ_FIND_KEY) state_q <= S_RSP;
								else if (rt == REQ_REMOVE_KEY) begin
									fa_q <= rd_prev;
									fb_q <= rd_next;
									state_q <= S_LINK;
								end else if (full) st_q <= ST_FULL;
								else begin
									fa_q <= (rt == REQ_INS_AFTER) ? cur_q : rd_prev;
									fb_q <= (rt == REQ_INS_AFTER) ? rd_next : cur_q;
									state_q <= S_ALLOC;
								end
							end else begin
								cur_q   <= rd_next;
								steps_q <= steps_q + CW'(1);
								state_q <= S_RD;
							end
						end
						default: ;
					endcase
				end
				S_ALLOC: begin
					// recycled node on top of stack (read in S_CHK) or fresh one
					if (rec_q != '0) begin
						newn_q <= LW'(fs_rd);
						rec_q  <= rec_q - CW'(1);
					end else begin
						newn_q <= LW'(bump_q);
						bump_q <= bump_q + CW'(1);
					end
					state_q <= S_LINK;
				end
				S_LINK: begin
					// insert: node written; read a. unlink: read a (prev).
					walk_q <= fa_q;
					if (is_push || is_ins) begin
						if (is_null(fa_q)) front_q <= newn_q;
						if (is_null(fb_q)) back_q  <= newn_q;
						count_q <= count_q + CW'(1);
					end else begin
						// b.prev becomes a
						newn_q <= fa_q;
						if (is_null(fa_q)) front_q <= fb_q;
						if (is_null(fb_q)) back_q  <= fa_q;
						count_q <= count_q - CW'(1);
					end
					state_q <= S_FIX;
				end
				S_FIX: begin
					cur_q   <= fb_q;
					state_q <= S_FIX2;
				end
				S_FIX2: begin
					if (!(is_push || is_ins)) rec_q <= rec_q + CW'(1);
					state_q <= S_RSP;
				end
				S_RSP: begin
					if (!rsp_v_q) begin
						rsp_q.status     <= st_q;
						rsp_q.read_value <= 32'(rd_q);
						rsp_q.length     <= 6'(count_q);
						rsp_q.is_empty   <= (count_q == '0);
						rsp_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== tb/deque_checker.sv =====
// ---------------------------------------------------------------------------
// deque_checker
// Watches both channels of the deque engine, keeps a shadow list of the
// engine's contents, predicts each response and compares it field by field.
// ---------------------------------------------------------------------------
module deque_checker
	import lldq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  req_t in_data,
	input  logic out_valid,
	input  logic out_stall,
	input  rsp_t out_data,
	output int   n_fail,
	output int   n_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = CAPACITY_DEF;

	// shadow list, front at index 0
	logic [31:0] shadow_list[$];
	rsp_t        rsp_pending[$];

	function automatic int key_pos(logic [31:0] key);
		for (int i = 0; i < shadow_list.size(); i++)
			if (shadow_list[i] == key) return i;
		return -1;
	endfunction

	function automatic rsp_t apply_req(req_t r);
		rsp_t        p;
		int          pos;
		req_type_t   op;
		p = '0;
		p.status = ST_OK;
		op = req_type_t'(r.req_type);
		case (r.req_type)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (shadow_list.size() >= CAP) p.status = ST_FULL;
				else if (op == REQ_PUSH_FRONT) shadow_list.push_front(r.new_value);
				else shadow_list.push_back(r.new_value);
			end
			REQ_INS_AFTER, REQ_INS_BEFORE: begin
				pos = key_pos(r.key_value);
				if (pos < 0) p.status = ST_NOTFOUND;
				else if (shadow_list.size() >= CAP) p.status = ST_FULL;
				else shadow_list.insert(op == REQ_INS_AFTER ? pos + 1 : pos, r.new_value);
			end
			REQ_PEEK_FRONT, REQ_POP_FRONT: begin
				if (shadow_list.size() == 0) p.status = ST_EMPTY;
				else begin
					p.read_value = shadow_list[0];
					if (op == REQ_POP_FRONT) void'(shadow_list.pop_front());
				end
			end
			REQ_PEEK_BACK, REQ_POP_BACK: begin
				if (shadow_list.size() == 0) p.status = ST_EMPTY;
				else begin
					p.read_value = shadow_list[$];
					if (op == REQ_POP_BACK) void'(shadow_list.pop_back());
				end
			end
			REQ_REMOVE_KEY: begin
				pos = key_pos(r.key_value);
				if (pos < 0) p.status = ST_NOTFOUND;
				else shadow_list.delete(pos);
			end
			REQ_FIND_KEY: begin
				if (key_pos(r.key_value) < 0) p.status = ST_NOTFOUND;
			end
			default: ;
		endcase
		p.length   = 6'(shadow_list.size());
		p.is_empty = (shadow_list.size() == 0);
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			n_fail <= 0;
			n_pending <= 0;
			shadow_list.delete();
			rsp_pending.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (rsp_pending.size() == 0) begin
					if (n_fail < 10)
						$display("unexpected response %p at %0t", out_data, $realtime);
					n_fail <= n_fail + 1;
				end else begin
					want = rsp_pending.pop_front();
					if (out_data.status !== want.status || out_data.read_value !== want.read_value
							|| out_data.length !== want.length
							|| out_data.is_empty !== want.is_empty) begin
						if (n_fail < 10)
							$display("mismatch at %0t: expected %p, got %p", $realtime, want,
								out_data);
						n_fail <= n_fail + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				rsp_pending.push_back(apply_req(in_data));
			n_pending <= rsp_pending.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Stimulus for the linked-list deque engine: directed corner cases, then
// random deque traffic with key searches, random gaps and back pressure.
// ---------------------------------------------------------------------------
module tb
	import lldq_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rsp_t out_data;
	int   n_fail;
	int   n_pending;
	bit   hold_rx = 1'b0;
	bit   rx_enable = 1'b0;

	// values recently pushed, so key searches mostly hit
	logic [31:0] used_vals[$];

	always #5 clk = ~clk;

	linked_list_deque_engine_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	deque_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.n_fail(n_fail), .n_pending(n_pending)
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] pick_val();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 32'h8000_0000;
		if (r == 1) return 32'h7fff_ffff;
		if (r == 2) return 32'hffff_ffff;
		if (r < 6) return $urandom_range(0, 15);
		return $urandom();
	endfunction

	function automatic logic [31:0] pick_key();
		if (used_vals.size() > 0 && $urandom_range(0, 3) != 0)
			return used_vals[$urandom_range(0, used_vals.size() - 1)];
		return pick_val();
	endfunction

	// one beat; waits for acceptance, then optional gap
	task automatic send(req_type_t op, logic [31:0] key, logic [31:0] val, int gap);
		in_data.req_type  <= op;
		in_data.key_value <= key;
		in_data.new_value <= val;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (op == REQ_PUSH_FRONT || op == REQ_PUSH_BACK || op == REQ_INS_AFTER
				|| op == REQ_INS_BEFORE) begin
			used_vals.push_back(val);
			if (used_vals.size() > 64) void'(used_vals.pop_front());
		end
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// receiver stall, on the falling edge
	always @(negedge clk) begin
		int r;
		if (!rx_enable || hold_rx) out_stall <= 1'b1;
		else begin
			r = $urandom_range(0, 99);
			out_stall <= (r < 25);
		end
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// long receiver hold-off while the sender keeps offering beats
	initial begin
		wait (arst_n);
		repeat (3000) @(posedge clk);
		hold_rx = 1'b1;
		repeat (300) @(posedge clk);
		hold_rx = 1'b0;
	end

	initial begin
		int          mode;
		int          op;
		logic [31:0] v;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		rx_enable = 1'b1;
		// directed: empty-list cases, extremes, every op, unused codes
		send(REQ_PEEK_FRONT, 0, 0, 0);
		send(REQ_POP_BACK, 0, 0, 1);
		send(REQ_FIND_KEY, 5, 0, 0);
		send(REQ_INS_AFTER, 5, 7, 0);
		send(REQ_REMOVE_KEY, 5, 0, 0);
		send(REQ_PUSH_FRONT, 0, 32'h8000_0000, 0);
		send(REQ_PUSH_BACK, 0, 32'h7fff_ffff, 2);
		send(REQ_INS_AFTER, 32'h8000_0000, 32'hffff_ffff, 0);
		send(REQ_INS_BEFORE, 32'h7fff_ffff, 0, 0);
		send(REQ_PEEK_BACK, 0, 0, 0);
		send(REQ_FIND_KEY, 32'hffff_ffff, 0, 0);
		send(REQ_REMOVE_KEY, 32'hffff_ffff, 0, 0);
		send(REQ_POP_FRONT, 0, 0, 0);
		send(req_type_t'(4'd10), 32'hffff_ffff, 32'hffff_ffff, 0);
		send(req_type_t'(4'd15), 0, 0, 0);
		// fill to capacity, then overflow pushes and insert
		for (int i = 0; i < 33; i++) send(REQ_PUSH_BACK, 0, i, 0);
		send(REQ_PUSH_FRONT, 0, 99, 0);
		send(REQ_INS_BEFORE, 3, 99, 0);
		send(REQ_INS_AFTER, 12345, 99, 0);
		send(REQ_FIND_KEY, 31, 0, 0);
		for (int i = 0; i < 34; i++) send(REQ_POP_FRONT, 0, 0, 0);
		// random phases: grow, churn, shrink
		for (int n = 0; n < 1460; n++) begin
			mode = (n / 150) % 3;
			op = $urandom_range(0, 99);
			if (op < 2) op = $urandom_range(10, 15);
			else if (mode == 0) op = (op < 60) ? $urandom_range(0, 3) : $urandom_range(4, 9);
			else if (mode == 2) op = (op < 60) ? $urandom_range(6, 8) : $urandom_range(0, 9);
			else op = $urandom_range(0, 9);
			v = pick_val();
			send(req_type_t'(4'(op)), pick_key(), v, gap_len());
		end
		in_valid <= 1'b0;
		while (n_pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (n_fail == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
